// ===== hdl/bcs_pkg.sv =====
`timescale 1ns / 1ps
package bcs_pkg;

    localparam int HELD_W = 6;

    localparam logic [HELD_W-1:0] MAX_HELD_SLASHES = HELD_W'(63);

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // controller to datapath
    typedef struct packed {
        logic load;   // take the input request into the datapath
        logic step;   // the current output request was taken
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic any;    // the request being loaded causes at least one result
        logic last;   // the pending result is the final one of its request
    } t_status;

endpackage

// ===== hdl/bcs_if.sv =====
`timescale 1ns / 1ps
interface bcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface bcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hdl/bcs_ctrl.sv =====
`timescale 1ns / 1ps
module bcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  bcs_pkg::t_status i_status,
    output bcs_pkg::t_cmd    o_cmd
);
    import bcs_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    // accept requests only while nothing is pending
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_cmd.load  = i_in_valid && o_in_ready;
    assign o_cmd.step  = o_out_valid && i_out_ready;

    // advance between accepting and emitting
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load && i_status.any) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (o_cmd.step && i_status.last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ===== hdl/bcs_dp.sv =====
`timescale 1ns / 1ps
module bcs_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_stream,
    input  bcs_pkg::t_cmd    i_cmd,
    output bcs_pkg::t_status o_status,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run
);
    import bcs_pkg::*;

    // scanner state
    logic              r_inside_comment, n_inside_comment;
    logic              r_star_seen,      n_star_seen;
    logic [HELD_W-1:0] r_held_slashes,   n_held_slashes;
    logic              r_line_has_content, n_line_has_content;
    logic              r_line_had_comment, n_line_had_comment;

    // pending results: a count of slashes, then an optional tail byte
    logic [HELD_W-1:0] r_cnt, n_cnt;
    logic              r_tail, n_tail;
    logic [7:0]        r_tail_byte;

    logic [HELD_W-1:0] ld_cnt;
    logic              ld_tail;

    // decode one input request against the scanner state
    always_comb begin
        n_inside_comment   = r_inside_comment;
        n_star_seen        = r_star_seen;
        n_held_slashes     = r_held_slashes;
        n_line_has_content = r_line_has_content;
        n_line_had_comment = r_line_had_comment;
        ld_cnt             = '0;
        ld_tail            = 1'b0;
        if (i_end_of_stream) begin
            ld_cnt             = r_held_slashes;
            n_inside_comment   = 1'b0;
            n_star_seen        = 1'b0;
            n_held_slashes     = '0;
            n_line_has_content = 1'b0;
            n_line_had_comment = 1'b0;
        end else if (r_inside_comment) begin
            if (i_in_byte == CH_STAR) begin
                n_star_seen = 1'b1;
            end else begin
                if (r_star_seen && i_in_byte == CH_SLASH) n_inside_comment = 1'b0;
                n_star_seen = 1'b0;
            end
        end else if (i_in_byte == CH_SLASH) begin
            // saturate the run; extra slashes are dropped
            if (r_held_slashes < MAX_HELD_SLASHES) n_held_slashes = r_held_slashes + 1'b1;
        end else if (i_in_byte == CH_STAR && r_held_slashes != '0) begin
            ld_cnt             = r_held_slashes - 1'b1;
            n_held_slashes     = '0;
            n_inside_comment   = 1'b1;
            n_star_seen        = 1'b0;
            n_line_had_comment = 1'b1;
        end else begin
            ld_cnt         = r_held_slashes;
            n_held_slashes = '0;
            if (i_in_byte == CH_NEWLINE) begin
                ld_tail            = r_line_has_content || !r_line_had_comment;
                n_line_has_content = 1'b0;
                n_line_had_comment = 1'b0;
            end else begin
                ld_tail            = 1'b1;
                n_line_has_content = 1'b1;
            end
        end
    end

    // pending result counters: load on accept, count down on each output
    always_comb begin
        n_cnt  = r_cnt;
        n_tail = r_tail;
        if (i_cmd.load) begin
            n_cnt  = ld_cnt;
            n_tail = ld_tail;
        end else if (i_cmd.step) begin
            if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
            else             n_tail = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_comment   <= 1'b0;
            r_star_seen        <= 1'b0;
            r_held_slashes     <= '0;
            r_line_has_content <= 1'b0;
            r_line_had_comment <= 1'b0;
            r_cnt              <= '0;
            r_tail             <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_inside_comment   <= n_inside_comment;
                r_star_seen        <= n_star_seen;
                r_held_slashes     <= n_held_slashes;
                r_line_has_content <= n_line_has_content;
                r_line_had_comment <= n_line_had_comment;
            end
            r_cnt  <= n_cnt;
            r_tail <= n_tail;
        end
    end

    // hold the tail byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_tail_byte <= i_in_byte;
    end

    assign o_status.any  = (ld_cnt != '0) || ld_tail;
    assign o_status.last = (r_cnt == '0) || (r_cnt == HELD_W'(1) && !r_tail);
    assign o_out_byte    = (r_cnt != '0) ? CH_SLASH : r_tail_byte;
    assign o_last_of_run = o_status.last;
endmodule

// ===== hdl/block_comment_stripper.sv =====
`timescale 1ns / 1ps
// Block comment stripper: removes slash-star comments from a byte stream.
// Input channel i_src carries one source byte per request (in_byte) or an
// end-of-stream marker (end_of_stream) that flushes held slashes and
// returns the scanner to its reset state.
// Output channel o_res carries the stripped text, one byte per request;
// last_of_run marks the final byte caused by one input request.
// An input request that causes no output (slash runs, comment bodies,
// dropped newlines) is taken and the block stays ready for the next
// request. A request that causes N output bytes occupies the block until
// its last byte is taken; each output byte is offered from registers and
// the next one is offered in the cycle after it is taken. N is the held
// slash count (up to 63, one less when a star opens a comment) plus at
// most one tail byte. The input is not ready while output bytes are pending.
// Reset (synchronous, active low) clears the comment, slash and line
// state and drops any pending output.
// When the receiver stalls, the current output byte holds and no new input
// request is taken until the last byte of the current one is taken.
module block_comment_stripper (
    input  logic i_clk,
    input  logic i_rst_n,
    bcs_in_if.sink    i_src,
    bcs_out_if.source o_res
);
    import bcs_pkg::*;

    t_cmd    cmd;
    t_status status;

    bcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_src.valid),
        .o_in_ready  (i_src.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bcs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_src.in_byte),
        .i_end_of_stream (i_src.end_of_stream),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_byte      (o_res.out_byte),
        .o_last_of_run   (o_res.last_of_run)
    );
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import bcs_pkg::*;

    // one source request and one stripped-text byte
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_src_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_byte;

    logic i_clk;
    logic i_rst_n;

    bcs_in_if  src_if ();
    bcs_out_if res_if ();

    block_comment_stripper DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if.sink),
        .o_res   (res_if.source)
    );

    t_src_req   pending_reqs[$];
    t_text_byte expected_text[$];
    t_src_req   cur_req;
    t_text_byte got_byte;
    t_text_byte want_byte;

    // scanner state mirrored from the block
    logic              in_cmt       = 1'b0;
    logic              star_pend    = 1'b0;
    logic [HELD_W-1:0] held         = '0;
    logic              line_content = 1'b0;
    logic              line_cmt     = 1'b0;

    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned hold_cycles = 0;
    int unsigned hold_left   = 0;

    int unsigned n_queued    = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_eos       = 0;
    int unsigned n_text      = 0;
    int unsigned n_errors    = 0;
    int unsigned longest_run = 0;

    // clock, and known levels on every input from time zero
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        src_if.valid = 1'b0;
        src_if.in_byte = 8'h00;
        src_if.end_of_stream = 1'b0;
        res_if.ready = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // compute the stripped bytes that one request causes
    task automatic strip_byte(input t_src_req req);
        t_text_byte run_q[$];
        int         n_slash;
        n_slash = 0;
        if (req.eos) begin
            n_slash = int'(held);
            in_cmt = 1'b0;
            star_pend = 1'b0;
            held = '0;
            line_content = 1'b0;
            line_cmt = 1'b0;
            repeat (n_slash) run_q.push_back('{CH_SLASH, 1'b0});
        end else if (in_cmt) begin
            if (req.data == CH_STAR) begin
                star_pend = 1'b1;
            end else begin
                if (star_pend && req.data == CH_SLASH) in_cmt = 1'b0;
                star_pend = 1'b0;
            end
        end else if (req.data == CH_SLASH) begin
            // saturate the run, drop the extra slashes
            if (held < MAX_HELD_SLASHES) held = held + 1'b1;
        end else if (req.data == CH_STAR && held != '0) begin
            // last held slash opens the comment
            n_slash = int'(held) - 1;
            repeat (n_slash) run_q.push_back('{CH_SLASH, 1'b0});
            held = '0;
            in_cmt = 1'b1;
            star_pend = 1'b0;
            line_cmt = 1'b1;
        end else begin
            n_slash = int'(held);
            repeat (n_slash) run_q.push_back('{CH_SLASH, 1'b0});
            held = '0;
            if (req.data == CH_NEWLINE) begin
                // drop the newline of a line that held only a comment
                if (line_content || !line_cmt) run_q.push_back('{req.data, 1'b0});
                line_content = 1'b0;
                line_cmt = 1'b0;
            end else begin
                line_content = 1'b1;
                run_q.push_back('{req.data, 1'b0});
            end
        end
        if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
        if (run_q.size() > longest_run) longest_run = run_q.size();
        foreach (run_q[i]) expected_text.push_back(run_q[i]);
    endtask

    // source side: predict on acceptance, then offer the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_if.valid <= 1'b0;
            src_if.in_byte <= 8'h00;
            src_if.end_of_stream <= 1'b0;
        end else begin
            if (src_if.valid && src_if.ready) begin
                strip_byte(cur_req);
                n_accepted++;
                if (cur_req.eos) n_eos++;
            end
            if (!src_if.valid || src_if.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    src_if.valid <= 1'b1;
                    src_if.in_byte <= cur_req.data;
                    src_if.end_of_stream <= cur_req.eos;
                end else begin
                    src_if.valid <= 1'b0;
                end
            end
        end
    end

    // result side ready: long hold-off when requested, else random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (hold_cycles > 0) begin
            hold_left = hold_cycles - 1;
            hold_cycles = 0;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each taken byte with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_byte = '{res_if.out_byte, res_if.last_of_run};
            n_text++;
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected byte out_byte=%02h last_of_run=%0b",
                         $time, got_byte.ch, got_byte.last);
                n_errors++;
            end else begin
                want_byte = expected_text.pop_front();
                if (got_byte.ch !== want_byte.ch) begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want_byte.ch, got_byte.ch);
                    n_errors++;
                end
                if (got_byte.last !== want_byte.last) begin
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want_byte.last, got_byte.last);
                    n_errors++;
                end
            end
        end
    end

    task automatic push_req(input logic [7:0] data, input logic eos);
        pending_reqs.push_back('{data, eos});
        n_queued++;
    endtask

    function automatic logic [7:0] body_byte();
        case ($urandom_range(7)) inside
            [0:1]:   return CH_STAR;
            2:       return CH_NEWLINE;
            3:       return CH_SLASH;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // comment body and closing star run
    task automatic push_comment_rest();
        int unsigned len;
        len = $urandom_range(6);
        repeat (len) push_req(body_byte(), 1'b0);
        len = $urandom_range(3, 1);
        repeat (len) push_req(CH_STAR, 1'b0);
        push_req(CH_SLASH, 1'b0);
    endtask

    // mostly well-formed text with comments, some noise
    task automatic queue_random(input int unsigned target);
        int unsigned start;
        int unsigned kind;
        int unsigned len;
        start = n_queued;
        while (n_queued - start < target) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                push_req(CH_SLASH, 1'b0);
                push_req(CH_STAR, 1'b0);
                push_comment_rest();
                if ($urandom_range(1)) push_req(CH_NEWLINE, 1'b0);
            end else if (kind < 50) begin
                len = $urandom_range(6, 1);
                repeat (len) begin
                    if ($urandom_range(1)) push_req(8'($urandom_range(126, 32)), 1'b0);
                    else push_req(8'($urandom_range(255)), 1'b0);
                end
            end else if (kind < 65) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(4, 1);
                repeat (len) push_req(CH_SLASH, 1'b0);
                case ($urandom_range(3))
                    0: push_req(8'($urandom_range(255)), 1'b0);
                    1: begin
                        push_req(CH_STAR, 1'b0);
                        push_comment_rest();
                    end
                    2: push_req(8'($urandom_range(255)), 1'b1);
                    default: push_req(CH_NEWLINE, 1'b0);
                endcase
            end else if (kind < 75) begin
                push_req(CH_NEWLINE, 1'b0);
            end else if (kind < 80) begin
                push_req(8'($urandom_range(255)), 1'b1);
            end else begin
                len = $urandom_range(4, 1);
                repeat (len) begin
                    push_req(($urandom_range(1) ? body_byte() : 8'($urandom_range(255))),
                             ($urandom_range(15) == 0));
                end
            end
        end
    endtask

    // hold the sender until every expected byte has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() > 0 || src_if.valid || expected_text.size() > 0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, comment open/close, newline rules, flushes
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b0);
        push_req(8'hFF, 1'b1);         // end with nothing held
        push_req(CH_SLASH, 1'b0);
        push_req(CH_STAR, 1'b0);       // open, no slash emitted
        push_req(CH_NEWLINE, 1'b0);    // newline inside comment
        push_req(CH_STAR, 1'b0);
        push_req(8'h71, 1'b0);         // star run broken, comment goes on
        push_req(CH_STAR, 1'b0);
        push_req(CH_STAR, 1'b0);
        push_req(CH_SLASH, 1'b0);      // close
        push_req(CH_NEWLINE, 1'b0);    // comment-only line, dropped
        push_req(CH_SLASH, 1'b0);
        push_req(CH_SLASH, 1'b0);
        push_req(CH_STAR, 1'b0);       // one slash out, comment opens
        push_req(8'h00, 1'b1);         // end inside comment
        push_req(CH_SLASH, 1'b0);
        push_req(8'h61, 1'b0);
        push_req(CH_SLASH, 1'b0);
        push_req(CH_SLASH, 1'b0);
        push_req(8'h80, 1'b1);         // flush two held slashes
        push_req(CH_NEWLINE, 1'b0);
        push_req(CH_SLASH, 1'b0);
        push_req(CH_NEWLINE, 1'b0);
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_cycles = 200;
        repeat (8) push_req(8'($urandom_range(126, 32)), 1'b0);
        // saturated slash run into plain byte and into star
        repeat (64) push_req(CH_SLASH, 1'b0);
        push_req(8'h78, 1'b0);
        repeat (64) push_req(CH_SLASH, 1'b0);
        push_req(CH_STAR, 1'b0);
        push_comment_rest();
        queue_random(10);
        wait_drained();

        idle_pct = 68;
        stall_pct = 0;
        queue_random(25);
        wait_drained();

        idle_pct = 0;
        stall_pct = 68;
        queue_random(25);
        wait_drained();

        idle_pct = 12;
        stall_pct = 12;
        queue_random(25);
        wait_drained();

        idle_pct = 0;
        stall_pct = 0;
        repeat (80) @(posedge i_clk);
        if (expected_text.size() != 0) begin
            $display("%0t: %0d expected bytes never arrived", $time, expected_text.size());
            n_errors++;
        end

        $display("Run: %0d requests accepted (%0d end-of-stream), %0d bytes checked,",
                 n_accepted, n_eos, n_text);
        $display("     longest burst from one request %0d bytes, %0d mismatches",
                 longest_run, n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
